@@ design/mfdm_pkg.sv @@
// shared types, constants and helpers for the motor feedback decoder
`default_nettype none

package mfdm_pkg;

    // decoded-frame queue between front and back
    localparam int FIFO_DEPTH = 8;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    // stream widths
    localparam int IN_DATA_W  = 64;
    localparam int OUT_DATA_W = 168;

    // angle constants in q16.16 degrees
    localparam logic signed [32:0] HALF_TURN_Q16 = 33'sd11796480;
    localparam logic signed [40:0] FULL_TURN_Q16 = 41'sd23592960;
    localparam logic signed [15:0] TURN_LIMIT    = 16'sd32767;

    // status code that marks a motor online and running
    localparam logic [3:0] STATUS_NORMAL = 4'd1;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ANGLE_GAIN   = 3'd0,
        REG_ANGLE_BASE   = 3'd1,
        REG_SPEED_GAIN   = 3'd2,
        REG_SPEED_BASE   = 3'd3,
        REG_TORQUE_GAIN  = 3'd4,
        REG_TORQUE_BASE  = 3'd5,
        REG_TOTAL_OFFSET = 3'd6
    } cfg_index_t;

    typedef struct packed {
        logic        [31:0] angle_gain;
        logic signed [31:0] angle_base;
        logic        [31:0] speed_gain;
        logic signed [31:0] speed_base;
        logic        [31:0] torque_gain;
        logic signed [31:0] torque_base;
        logic signed [31:0] total_offset;
    } cfg_t;

    // one scaled frame as it travels through the queue
    typedef struct packed {
        logic        [3:0]  status;
        logic signed [31:0] angle;
        logic signed [31:0] speed;
        logic signed [31:0] torque;
        logic signed [7:0]  temperature;
    } feedback_t;

    // base + scaled term, clipped to the signed 32-bit range
    function automatic logic signed [31:0] sat_scale(input logic signed [31:0] base,
                                                     input logic [31:0] prod);
        logic [33:0] sum;
        sum = {{2{base[31]}}, base} + {2'b00, prod};
        // the scaled term is never negative, so only the upper limit can be crossed
        if (!sum[33] && (sum[32] || sum[31])) begin
            sat_scale = 32'sh7fffffff;
        end else begin
            sat_scale = sum[31:0];
        end
    endfunction

endpackage

`default_nettype wire

@@ design/mfdm_front.sv @@
// front end: accepts frames, unpacks fields and scales them into the queue
`default_nettype none

module mfdm_front
    import mfdm_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [IN_DATA_W-1:0] s_tdata,  // frame_data
    input  wire cfg_t                 cfg,
    input  wire logic [FIFO_CW-1:0]   fifo_level,
    output logic                      push,
    output feedback_t                 push_item
);

    logic              accept;
    logic [FIFO_CW:0]  committed;
    logic [47:0]       p_full;
    logic [43:0]       v_full;
    logic [43:0]       t_full;

    logic              s1_valid_reg;
    logic              s1_valid_next;
    logic [31:0]       p_prod_reg;
    logic [27:0]       v_prod_reg;
    logic [27:0]       t_prod_reg;
    logic [3:0]        status_reg;
    logic [7:0]        temp_reg;

    // credit check: queue entries in use plus the frame in the multiplier stage
    assign committed = {1'b0, fifo_level} + {{FIFO_CW{1'b0}}, s1_valid_reg};
    assign s_tready  = committed < (FIFO_CW + 1)'(FIFO_DEPTH);
    assign accept    = s_tvalid && s_tready;

    // raw count times gain, one multiplier per field
    assign p_full = 48'(s_tdata[55:40]) * 48'(cfg.angle_gain);
    assign v_full = 44'(s_tdata[39:28]) * 44'(cfg.speed_gain);
    assign t_full = 44'(s_tdata[27:16]) * 44'(cfg.torque_gain);

    assign s1_valid_next = accept;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    // product stage keeps the integer part of each q16.16 product
    always_ff @(posedge aclk) begin
        if (accept) begin
            p_prod_reg <= p_full[47:16];
            v_prod_reg <= v_full[43:16];
            t_prod_reg <= t_full[43:16];
            status_reg <= s_tdata[63:60];
            temp_reg   <= s_tdata[7:0];
        end
    end

    // add base and clip, straight into the queue
    always_comb begin
        push_item.status      = status_reg;
        push_item.angle       = sat_scale(cfg.angle_base, p_prod_reg);
        push_item.speed       = sat_scale(cfg.speed_base, {4'b0000, v_prod_reg});
        push_item.torque      = sat_scale(cfg.torque_base, {4'b0000, t_prod_reg});
        push_item.temperature = temp_reg;
    end

    assign push = s1_valid_reg;

endmodule

`default_nettype wire

@@ design/mfdm_fifo.sv @@
// short queue of scaled frames between front and back
`default_nettype none

module mfdm_fifo
    import mfdm_pkg::*;
(
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               push,
    input  wire feedback_t          push_item,
    input  wire logic               pop,
    output feedback_t               head_item,
    output logic                    not_empty,
    output logic [FIFO_CW-1:0]      level
);

    feedback_t            mem_reg [FIFO_DEPTH];
    logic [FIFO_AW-1:0]   wr_ptr_reg;
    logic [FIFO_AW-1:0]   wr_ptr_next;
    logic [FIFO_AW-1:0]   rd_ptr_reg;
    logic [FIFO_AW-1:0]   rd_ptr_next;
    logic [FIFO_CW-1:0]   count_reg;
    logic [FIFO_CW-1:0]   count_next;
    logic                 do_pop;

    assign not_empty = count_reg != '0;
    assign level     = count_reg;
    assign head_item = mem_reg[rd_ptr_reg];
    assign do_pop    = pop && not_empty;

    // pointer and fill count update
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == FIFO_AW'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == FIFO_AW'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (!push && do_pop) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // storage
    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

`default_nettype wire

@@ design/mfdm_back.sv @@
// back end: turn tracking, total angle and the output register
`default_nettype none

module mfdm_back
    import mfdm_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  fifo_not_empty,
    input  wire feedback_t             head_item,
    output logic                       pop,
    input  wire logic signed [31:0]    total_offset,
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    // status_code, angle, speed, torque, temperature, turn_count, accum_angle,
    // online_refresh, two zero pad bits
    output logic [OUT_DATA_W-1:0]      m_tdata
);

    logic                     a_ready;
    logic                     b_ready;
    logic signed [32:0]       diff;
    logic                     wrap_down;
    logic                     wrap_up;
    logic signed [40:0]       total;

    logic                     a_valid_reg;
    logic                     a_valid_next;
    feedback_t                a_item_reg;
    logic signed [31:0]       last_angle_reg;
    logic signed [31:0]       last_angle_next;
    logic signed [15:0]       turns_reg;
    logic signed [15:0]       turns_next;
    logic signed [40:0]       turns_q_reg;
    logic signed [40:0]       turns_q_next;
    logic                     m_tvalid_reg;
    logic                     m_tvalid_next;
    logic [OUT_DATA_W-1:0]    m_tdata_reg;
    logic [OUT_DATA_W-1:0]    m_tdata_next;

    // handshake between tracking stage and output register
    assign b_ready = !m_tvalid_reg || m_tready;
    assign a_ready = !a_valid_reg || b_ready;
    assign pop     = fifo_not_empty && a_ready;

    // jump from the previous angle, strict half-turn compare
    assign diff      = {head_item.angle[31], head_item.angle}
                     - {last_angle_reg[31], last_angle_reg};
    assign wrap_down = diff > HALF_TURN_Q16;
    assign wrap_up   = diff < -HALF_TURN_Q16;

    // turn counter and its q16.16 image move together, saturating at the limit
    always_comb begin
        turns_next      = turns_reg;
        turns_q_next    = turns_q_reg;
        last_angle_next = last_angle_reg;
        if (pop) begin
            last_angle_next = head_item.angle;
            if (wrap_down) begin
                if (turns_reg > -TURN_LIMIT) begin
                    turns_next   = turns_reg - 16'sd1;
                    turns_q_next = turns_q_reg - FULL_TURN_Q16;
                end
            end else if (wrap_up) begin
                if (turns_reg < TURN_LIMIT) begin
                    turns_next   = turns_reg + 16'sd1;
                    turns_q_next = turns_q_reg + FULL_TURN_Q16;
                end
            end
        end
    end

    assign a_valid_next = a_ready ? pop : a_valid_reg;

    // the tracking stage loads on every pop, so the turn registers always
    // belong to the frame held there
    assign total = turns_q_reg
                 + {{9{a_item_reg.angle[31]}}, a_item_reg.angle}
                 - {{9{total_offset[31]}}, total_offset};

    always_comb begin
        m_tvalid_next = b_ready ? a_valid_reg : m_tvalid_reg;
        m_tdata_next  = {2'b00,
                         a_item_reg.status == STATUS_NORMAL,
                         total,
                         turns_reg,
                         a_item_reg.temperature,
                         a_item_reg.torque,
                         a_item_reg.speed,
                         a_item_reg.angle,
                         a_item_reg.status};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg    <= 1'b0;
            m_tvalid_reg   <= 1'b0;
            last_angle_reg <= '0;
            turns_reg      <= '0;
            turns_q_reg    <= '0;
        end else begin
            a_valid_reg    <= a_valid_next;
            m_tvalid_reg   <= m_tvalid_next;
            last_angle_reg <= last_angle_next;
            turns_reg      <= turns_next;
            turns_q_reg    <= turns_q_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (pop) begin
            a_item_reg <= head_item;
        end
        if (a_valid_reg && b_ready) begin
            m_tdata_reg <= m_tdata_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

`default_nettype wire

@@ design/motor_feedback_decode_multiturn.sv @@
// Motor feedback frame decoder with multi-turn angle tracking. Takes one
// 64-bit feedback frame per transaction and returns one decoded transaction:
// scaled angle, speed and torque (base + raw*gain >> 16, clipped to 32 bits),
// temperature, a saturating turn counter and the total angle
// 360*turns + angle - total_offset. Throughput is one frame per clock while
// m_tready and the queue credit allow; a frame passes the gain multiplier
// stage, the eight-entry queue write, the turn tracking stage and the output
// register. The front end stalls only when the queue plus the multiplier
// stage hold eight frames. Configuration gains apply at frame acceptance,
// bases and offset later; write them only while the block is idle.
`default_nettype none

module motor_feedback_decode_multiturn
    import mfdm_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [IN_DATA_W-1:0]  s_tdata,  // frame_data
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    // status_code, angle, speed, torque, temperature, turn_count, accum_angle,
    // online_refresh, two zero pad bits
    output logic [OUT_DATA_W-1:0]      m_tdata
);

    cfg_t                cfg_reg;
    cfg_t                cfg_next;
    logic                push;
    feedback_t           push_item;
    logic                pop;
    feedback_t           head_item;
    logic                fifo_not_empty;
    logic [FIFO_CW-1:0]  fifo_level;

    // configuration register file
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_we) begin
            case (cfg_index_t'(cfg_index))
                REG_ANGLE_GAIN:   cfg_next.angle_gain   = cfg_wdata;
                REG_ANGLE_BASE:   cfg_next.angle_base   = cfg_wdata;
                REG_SPEED_GAIN:   cfg_next.speed_gain   = cfg_wdata;
                REG_SPEED_BASE:   cfg_next.speed_base   = cfg_wdata;
                REG_TORQUE_GAIN:  cfg_next.torque_gain  = cfg_wdata;
                REG_TORQUE_BASE:  cfg_next.torque_base  = cfg_wdata;
                REG_TOTAL_OFFSET: cfg_next.total_offset = cfg_wdata;
                default: begin
                    cfg_next = cfg_reg;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    // unpack and scale
    mfdm_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .cfg        (cfg_reg),
        .fifo_level (fifo_level),
        .push       (push),
        .push_item  (push_item)
    );

    // decoupling queue
    mfdm_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .head_item (head_item),
        .not_empty (fifo_not_empty),
        .level     (fifo_level)
    );

    // turn tracking and output
    mfdm_back u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .fifo_not_empty (fifo_not_empty),
        .head_item      (head_item),
        .pop            (pop),
        .total_offset   (cfg_reg.total_offset),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata)
    );

`ifndef SYNTHESIS
    // the credit check must keep the queue from overflowing
    assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> (fifo_level < FIFO_CW'(FIFO_DEPTH)) || pop)
        else $error("queue written while full");

    assert property (@(posedge aclk) disable iff (!aresetn)
        fifo_level <= FIFO_CW'(FIFO_DEPTH))
        else $error("queue level beyond depth");

    // turn counter never leaves its saturating range
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[123:108] != 16'h8000)
        else $error("turn counter out of range");

    // refresh flag follows the reported status
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[165] == (m_tdata[3:0] == STATUS_NORMAL))
        else $error("online refresh does not match status");
`endif

endmodule

`default_nettype wire
